### rtl/core/polygon_clip_rect_stream_defines.svh
// Assertion macros for the checker file of the clipping block.
`ifndef POLYGON_CLIP_RECT_STREAM_DEFINES_SVH
`define POLYGON_CLIP_RECT_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pcr_pkg.sv
package pcr_pkg;

  localparam int COORD_W    = 16;
  localparam int NUM_STAGES = 4;
  localparam int STAGE_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int STK_DEPTH  = NUM_STAGES + 1;
  localparam int STK_AW     = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   end_of_polygon;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   has_vertex;
    logic   polygon_done;
  } out_item_t;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 2'd3;

  // Edge stage codes; STG_OUT marks a vertex that left the last stage.
  localparam logic [STAGE_W-1:0] STG_MAX_X = 3'd0;
  localparam logic [STAGE_W-1:0] STG_MAX_Y = 3'd1;
  localparam logic [STAGE_W-1:0] STG_MIN_X = 3'd2;
  localparam logic [STAGE_W-1:0] STG_MIN_Y = 3'd3;
  localparam logic [STAGE_W-1:0] STG_OUT   = 3'd4;

  localparam coord_t RST_MIN_X = 16'sd0;
  localparam coord_t RST_MAX_X = 16'sd1023;
  localparam coord_t RST_MIN_Y = 16'sd0;
  localparam coord_t RST_MAX_Y = 16'sd767;

  typedef struct packed {
    logic   is_x_axis;
    coord_t bound;
    coord_t p1x;
    coord_t p1y;
    coord_t p2x;
    coord_t p2y;
  } cross_req_t;

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    coord_t             x;
    coord_t             y;
  } stk_ent_t;

endpackage

### rtl/core/pcr_cross.sv
module pcr_cross (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pcr_pkg::cross_req_t req,
  output logic               done,
  output pcr_pkg::coord_t    result
);

  localparam int D_W   = pcr_pkg::COORD_W + 1;
  localparam int P_W   = 2 * D_W;
  localparam int R_W   = pcr_pkg::COORD_W + 3;
  localparam int CNT_W = $clog2(P_W + 1);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_MUL  = 2'd1;
  localparam logic [1:0] C_DIV  = 2'd2;
  localparam logic [1:0] C_RND  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic signed [D_W-1:0] a_r, b_r, d_r;
  pcr_pkg::coord_t       base_r;
  logic [P_W-1:0]        prod_r;
  logic [D_W-1:0]        dmag_r;
  logic [D_W:0]          rem_r;
  logic                  neg_r, dz_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  done_r;
  pcr_pkg::coord_t       result_r;

  logic signed [D_W-1:0] a_in, b_in, d_in;
  pcr_pkg::coord_t       base_in;
  logic [D_W-1:0]        amag, bmag, dmag;
  logic [D_W:0]          try_v;
  logic                  ge;
  logic signed [R_W-1:0] base_e, q_e, ip, res_v;
  logic                  rnz;
  logic [D_W-1:0]        g;
  logic [D_W:0]          twog, dcmp;

  always_comb begin
    if (req.is_x_axis) begin
      a_in    = D_W'(req.bound) - D_W'(req.p1x);
      b_in    = D_W'(req.p2y) - D_W'(req.p1y);
      d_in    = D_W'(req.p2x) - D_W'(req.p1x);
      base_in = req.p1y;
    end else begin
      a_in    = D_W'(req.bound) - D_W'(req.p1y);
      b_in    = D_W'(req.p2x) - D_W'(req.p1x);
      d_in    = D_W'(req.p2y) - D_W'(req.p1y);
      base_in = req.p1x;
    end
  end

  assign amag = a_r[D_W-1] ? D_W'(-a_r) : D_W'(a_r);
  assign bmag = b_r[D_W-1] ? D_W'(-b_r) : D_W'(b_r);
  assign dmag = d_r[D_W-1] ? D_W'(-d_r) : D_W'(d_r);

  assign try_v = {rem_r[D_W-1:0], prod_r[P_W-1]};
  assign ge    = try_v >= {1'b0, dmag_r};

  // Rounding of base +/- quotient, half away from zero on the final value.
  always_comb begin
    base_e = R_W'(base_r);
    q_e    = R_W'({2'b00, prod_r[D_W-1:0]});
    rnz    = rem_r != '0;
    if (neg_r) begin
      ip = base_e - q_e - R_W'(rnz);
      g  = dmag_r - rem_r[D_W-1:0];
    end else begin
      ip = base_e + q_e;
      g  = rem_r[D_W-1:0];
    end
    twog = {g, 1'b0};
    dcmp = {1'b0, dmag_r};
    priority if (dz_r) begin
      res_v = base_e;
    end else if (!rnz) begin
      res_v = ip;
    end else if (twog > dcmp) begin
      res_v = ip + R_W'(1);
    end else if (twog < dcmp) begin
      res_v = ip;
    end else begin
      res_v = ip[R_W-1] ? ip : ip + R_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: if (start) state_nxt = C_MUL;
      C_MUL:  state_nxt = C_DIV;
      C_DIV:  if (cnt_r == CNT_W'(P_W - 1)) state_nxt = C_RND;
      C_RND:  state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == C_RND);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      C_IDLE: begin
        a_r    <= a_in;
        b_r    <= b_in;
        d_r    <= d_in;
        base_r <= base_in;
      end
      C_MUL: begin
        prod_r <= P_W'(amag) * P_W'(bmag);
        dmag_r <= dmag;
        neg_r  <= a_r[D_W-1] ^ b_r[D_W-1] ^ d_r[D_W-1];
        dz_r   <= d_r == '0;
        rem_r  <= '0;
        cnt_r  <= '0;
      end
      C_DIV: begin
        rem_r  <= ge ? try_v - {1'b0, dmag_r} : try_v;
        prod_r <= {prod_r[P_W-2:0], ge};
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      C_RND: begin
        result_r <= res_v[pcr_pkg::COORD_W-1:0];
      end
      default: ;
    endcase
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

### rtl/core/polygon_clip_rect_stream.sv
// Channel   Direction  Payload               Handshake
// in_       input      pcr_pkg::in_item_t    in_valid / in_stall
// out_      output     pcr_pkg::out_item_t   out_valid / out_stall
// cfg_      input      index + 16-bit data   cfg_we, no wait
//
// Without a crossing or an output stall, in_stall stays high after an item is
// taken for each edge stage step or closing step of the sequencer, for the
// decision to flush and for the flush itself.
// Each crossing holds the sequencer longer in the shared crossing unit (a
// multiply step, 34 restoring divide steps of one bit each, a rounding step
// and the hand-back), and its vertex then takes one step for every stage it
// still passes.
// Reset (rst_n low, synchronous) restores the reset window and clears all
// per-stage state. The block stalls its input until an item is fully done,
// and waits on out_stall only when a result must move into the output register.
module polygon_clip_rect_stream (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pcr_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pcr_pkg::out_item_t                 out_item,
  input  logic                               cfg_we,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcr_pkg::COORD_W-1:0]        cfg_wdata
);

  localparam int NS = pcr_pkg::NUM_STAGES;
  localparam int SW = pcr_pkg::STAGE_W;
  localparam int AW = pcr_pkg::STK_AW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_CROSS = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_r, state_nxt;

  // Clip window.
  pcr_pkg::coord_t min_x_r, max_x_r, min_y_r, max_y_r;

  // Per-stage polygon state.
  logic            seen_r   [NS];
  pcr_pkg::coord_t first_x_r[NS];
  pcr_pkg::coord_t first_y_r[NS];
  pcr_pkg::coord_t prev_x_r [NS];
  pcr_pkg::coord_t prev_y_r [NS];

  // Pending vertices, processed depth first so results come out in order.
  pcr_pkg::stk_ent_t stk_r[pcr_pkg::STK_DEPTH];
  logic [AW-1:0]     sp_r, sp_nxt;

  logic          last_r, last_nxt;
  logic [SW-1:0] fin_k_r, fin_k_nxt;
  logic [SW-1:0] dest_r, dest_nxt;
  logic          axis_x_r, axis_x_nxt;
  pcr_pkg::coord_t bound_r, bound_nxt;

  pcr_pkg::coord_t    hold_x_r, hold_y_r;
  logic               hold_v_r, hold_v_nxt, hold_ld;
  pcr_pkg::out_item_t out_r, out_nxt;
  logic               out_v_r, out_v_nxt;
  logic               out_free;

  // Stack write port, one entry per cycle.
  logic              stk_we;
  logic [AW-1:0]     stk_wa;
  pcr_pkg::stk_ent_t stk_wd;

  // Stage state updates.
  logic          set_seen, clr_seen, upd_prev;
  logic [1:0]    st_k;

  // Edge evaluation.
  pcr_pkg::stk_ent_t  top_e;
  logic [1:0]         ev_k;
  pcr_pkg::coord_t    ev_px, ev_py, ev_cx, ev_cy, ev_bound;
  logic               ev_pin, ev_cin;
  logic               cross_start;
  pcr_pkg::cross_req_t cross_req;
  logic               cross_done;
  pcr_pkg::coord_t    cross_res;

  assign out_free = !out_v_r || !out_stall;
  assign top_e    = stk_r[sp_r - AW'(1)];

  function automatic logic inside_f(input logic [1:0] k, input pcr_pkg::coord_t x,
                                    input pcr_pkg::coord_t y, input pcr_pkg::coord_t mnx,
                                    input pcr_pkg::coord_t mxx, input pcr_pkg::coord_t mny,
                                    input pcr_pkg::coord_t mxy);
    logic r;
    unique case ({1'b0, k})
      pcr_pkg::STG_MAX_X: r = x < mxx;
      pcr_pkg::STG_MAX_Y: r = y < mxy;
      pcr_pkg::STG_MIN_X: r = x > mnx;
      default:            r = y > mny;
    endcase
    return r;
  endfunction

  // The edge under test comes from the popped vertex in normal flow, or from
  // the closing edge back to the first vertex while the polygon is finished.
  always_comb begin
    if (sp_r != '0) begin
      ev_k  = top_e.stage[1:0];
      ev_cx = top_e.x;
      ev_cy = top_e.y;
    end else begin
      ev_k  = fin_k_r[1:0];
      ev_cx = first_x_r[fin_k_r[1:0]];
      ev_cy = first_y_r[fin_k_r[1:0]];
    end
    ev_px  = prev_x_r[ev_k];
    ev_py  = prev_y_r[ev_k];
    ev_pin = inside_f(ev_k, ev_px, ev_py, min_x_r, max_x_r, min_y_r, max_y_r);
    ev_cin = inside_f(ev_k, ev_cx, ev_cy, min_x_r, max_x_r, min_y_r, max_y_r);
    unique case ({1'b0, ev_k})
      pcr_pkg::STG_MAX_X: ev_bound = max_x_r;
      pcr_pkg::STG_MAX_Y: ev_bound = max_y_r;
      pcr_pkg::STG_MIN_X: ev_bound = min_x_r;
      default:            ev_bound = min_y_r;
    endcase
  end

  assign cross_req = '{is_x_axis: ~ev_k[0], bound: ev_bound,
                       p1x: ev_px, p1y: ev_py, p2x: ev_cx, p2y: ev_cy};

  pcr_cross u_cross (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cross_start),
    .req    (cross_req),
    .done   (cross_done),
    .result (cross_res)
  );

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    sp_nxt      = sp_r;
    last_nxt    = last_r;
    fin_k_nxt   = fin_k_r;
    dest_nxt    = dest_r;
    axis_x_nxt  = axis_x_r;
    bound_nxt   = bound_r;
    hold_v_nxt  = hold_v_r;
    hold_ld     = 1'b0;
    out_v_nxt   = out_v_r && out_stall;
    out_nxt     = out_r;
    stk_we      = 1'b0;
    stk_wa      = sp_r;
    stk_wd      = top_e;
    set_seen    = 1'b0;
    clr_seen    = 1'b0;
    upd_prev    = 1'b0;
    st_k        = ev_k;
    cross_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          stk_we    = 1'b1;
          stk_wa    = '0;
          stk_wd    = '{stage: pcr_pkg::STG_MAX_X, x: in_item.vertex_x,
                        y: in_item.vertex_y};
          sp_nxt    = AW'(1);
          last_nxt  = in_item.end_of_polygon;
          fin_k_nxt = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sp_r != '0) begin
          if (top_e.stage == pcr_pkg::STG_OUT) begin
            // A result is kept back one place so the last one can be flagged.
            if (!hold_v_r || out_free) begin
              if (hold_v_r) begin
                out_nxt   = '{out_x: hold_x_r, out_y: hold_y_r,
                              has_vertex: 1'b1, polygon_done: 1'b0};
                out_v_nxt = 1'b1;
              end
              hold_ld    = 1'b1;
              hold_v_nxt = 1'b1;
              sp_nxt     = sp_r - AW'(1);
            end
          end else if (!seen_r[ev_k]) begin
            set_seen = 1'b1;
            sp_nxt   = sp_r - AW'(1);
          end else begin
            upd_prev = 1'b1;
            if (ev_cin) begin
              stk_we = 1'b1;
              stk_wa = sp_r - AW'(1);
              stk_wd = '{stage: SW'({1'b0, ev_k}) + SW'(1), x: ev_cx, y: ev_cy};
            end else begin
              sp_nxt = sp_r - AW'(1);
            end
            if (ev_pin != ev_cin) begin
              cross_start = 1'b1;
              dest_nxt    = SW'({1'b0, ev_k}) + SW'(1);
              axis_x_nxt  = ~ev_k[0];
              bound_nxt   = ev_bound;
              state_nxt   = S_CROSS;
            end
          end
        end else if (last_r && !fin_k_r[SW-1]) begin
          fin_k_nxt = fin_k_r + SW'(1);
          if (seen_r[ev_k]) begin
            clr_seen = 1'b1;
            if (ev_cin) begin
              stk_we = 1'b1;
              stk_wa = '0;
              stk_wd = '{stage: SW'({1'b0, ev_k}) + SW'(1), x: ev_cx, y: ev_cy};
              sp_nxt = AW'(1);
            end
            if (ev_pin != ev_cin) begin
              cross_start = 1'b1;
              dest_nxt    = SW'({1'b0, ev_k}) + SW'(1);
              axis_x_nxt  = ~ev_k[0];
              bound_nxt   = ev_bound;
              state_nxt   = S_CROSS;
            end
          end
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_CROSS: begin
        if (cross_done) begin
          stk_we    = 1'b1;
          stk_wa    = sp_r;
          stk_wd    = axis_x_r ? '{stage: dest_r, x: bound_r, y: cross_res}
                               : '{stage: dest_r, x: cross_res, y: bound_r};
          sp_nxt    = sp_r + AW'(1);
          state_nxt = S_RUN;
        end
      end
      S_FLUSH: begin
        if (hold_v_r || last_r) begin
          if (out_free) begin
            if (hold_v_r) begin
              out_nxt = '{out_x: hold_x_r, out_y: hold_y_r,
                          has_vertex: 1'b1, polygon_done: last_r};
            end else begin
              out_nxt = '{out_x: '0, out_y: '0, has_vertex: 1'b0, polygon_done: 1'b1};
            end
            out_v_nxt  = 1'b1;
            hold_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sp_r     <= '0;
      last_r   <= 1'b0;
      fin_k_r  <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      min_x_r  <= pcr_pkg::RST_MIN_X;
      max_x_r  <= pcr_pkg::RST_MAX_X;
      min_y_r  <= pcr_pkg::RST_MIN_Y;
      max_y_r  <= pcr_pkg::RST_MAX_Y;
      for (int i = 0; i < NS; i++) begin
        seen_r[i]    <= 1'b0;
        first_x_r[i] <= '0;
        first_y_r[i] <= '0;
        prev_x_r[i]  <= '0;
        prev_y_r[i]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      sp_r     <= sp_nxt;
      last_r   <= last_nxt;
      fin_k_r  <= fin_k_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pcr_pkg::CFG_MIN_X: min_x_r <= cfg_wdata;
          pcr_pkg::CFG_MAX_X: max_x_r <= cfg_wdata;
          pcr_pkg::CFG_MIN_Y: min_y_r <= cfg_wdata;
          default:            max_y_r <= cfg_wdata;
        endcase
      end
      if (set_seen) begin
        seen_r[st_k]    <= 1'b1;
        first_x_r[st_k] <= ev_cx;
        first_y_r[st_k] <= ev_cy;
        prev_x_r[st_k]  <= ev_cx;
        prev_y_r[st_k]  <= ev_cy;
      end
      if (upd_prev) begin
        prev_x_r[st_k] <= ev_cx;
        prev_y_r[st_k] <= ev_cy;
      end
      if (clr_seen) begin
        seen_r[st_k] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dest_r   <= dest_nxt;
    axis_x_r <= axis_x_nxt;
    bound_r  <= bound_nxt;
    out_r    <= out_nxt;
    if (stk_we) begin
      stk_r[stk_wa] <= stk_wd;
    end
    if (hold_ld) begin
      hold_x_r <= top_e.x;
      hold_y_r <= top_e.y;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

### rtl/core/pcr_checker.sv
`include "polygon_clip_rect_stream_defines.svh"

module pcr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pcr_pkg::out_item_t out_item
);

  `PCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled item changed")
  `PCR_ASSERT_NOW(a_empty_done, out_valid && !out_item.has_vertex, out_item.polygon_done, "empty item not last")
  `PCR_ASSERT_NOW(a_empty_zero, out_valid && !out_item.has_vertex, out_item.out_x == '0 && out_item.out_y == '0, "empty item has coordinates")
  `PCR_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "accepted item did not make the block busy")

endmodule

bind polygon_clip_rect_stream pcr_checker u_pcr_checker (.*);

### sim/tb_polygon_clip_rect_stream.sv
`timescale 1ns / 100ps

module tb_polygon_clip_rect_stream;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  pcr_pkg::in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pcr_pkg::out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [pcr_pkg::CFG_IDX_W-1:0] cfg_index = pcr_pkg::CFG_MIN_X;
  logic [pcr_pkg::COORD_W-1:0]   cfg_wdata = '0;

  polygon_clip_rect_stream DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // The block may still be working on an item that gives no vertex after the
  // last expected vertex came out, so register writes and the end of the run
  // wait this long. It covers several crossings.
  localparam int SETTLE_CYCLES = 800;

  // Idle percentages of the sender and the receiver, changed as the run goes.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  failed = 1'b0;
  int  items_sent = 0;

  // Local copy of the clip window, sign-extended.
  longint win_min_x = 0, win_max_x = 1023, win_min_y = 0, win_max_y = 767;

  // Per-stage memory of the edge clipper: first and previous vertex.
  longint first_vx[pcr_pkg::NUM_STAGES], first_vy[pcr_pkg::NUM_STAGES];
  longint prev_vx[pcr_pkg::NUM_STAGES], prev_vy[pcr_pkg::NUM_STAGES];
  bit     vertex_seen[pcr_pkg::NUM_STAGES];

  // Vertices handed from one stage to the next while one item is clipped.
  longint hand_x[$], hand_y[$];

  // Clipped vertices still to come out of the block, oldest first.
  pcr_pkg::out_item_t clipped_due[$];

  function automatic bit inside_edge(int k, longint x, longint y);
    case (k)
      0: return x < win_max_x;
      1: return y < win_max_y;
      2: return x > win_min_x;
      default: return y > win_min_y;
    endcase
  endfunction

  // base + num/den, rounded half away from zero.
  function automatic longint round_div(longint base, longint num, longint den);
    longint t;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    t = base * den + num;
    if (t >= 0) return (2 * t + den) / (2 * den);
    return -((-2 * t + den) / (2 * den));
  endfunction

  // Applies one edge of stage k from (ax,ay) to (bx,by), handing any kept
  // vertices on to the next stage.
  task automatic edge_step(int k, longint ax, longint ay, longint bx, longint by);
    bit     a_in, b_in;
    longint bound, cx, cy;
    a_in = inside_edge(k, ax, ay);
    b_in = inside_edge(k, bx, by);
    if (a_in != b_in) begin
      if (k == 0 || k == 2) begin
        bound = (k == 0) ? win_max_x : win_min_x;
        cx = bound;
        cy = (bx == ax) ? ay : round_div(ay, (bound - ax) * (by - ay), bx - ax);
      end else begin
        bound = (k == 1) ? win_max_y : win_min_y;
        cy = bound;
        cx = (by == ay) ? ax : round_div(ax, (bound - ay) * (bx - ax), by - ay);
      end
      hand_x.push_back(cx);
      hand_y.push_back(cy);
    end
    if (b_in) begin
      hand_x.push_back(bx);
      hand_y.push_back(by);
    end
  endtask

  // Runs one vertex through the four stages and returns the clipped vertices.
  task automatic clip_vertex(pcr_pkg::in_item_t it, output pcr_pkg::out_item_t res[$]);
    longint cur_x[$], cur_y[$];
    pcr_pkg::out_item_t r;
    cur_x = {longint'(it.vertex_x)};
    cur_y = {longint'(it.vertex_y)};
    res = {};
    for (int k = 0; k < pcr_pkg::NUM_STAGES; k++) begin
      hand_x = {};
      hand_y = {};
      foreach (cur_x[i]) begin
        if (!vertex_seen[k]) begin
          vertex_seen[k] = 1'b1;
          first_vx[k] = cur_x[i];
          first_vy[k] = cur_y[i];
        end else begin
          edge_step(k, prev_vx[k], prev_vy[k], cur_x[i], cur_y[i]);
        end
        prev_vx[k] = cur_x[i];
        prev_vy[k] = cur_y[i];
      end
      // Closing edge back to the first vertex of the polygon.
      if (it.end_of_polygon && vertex_seen[k]) begin
        edge_step(k, prev_vx[k], prev_vy[k], first_vx[k], first_vy[k]);
        vertex_seen[k] = 1'b0;
      end
      cur_x = hand_x;
      cur_y = hand_y;
    end
    foreach (cur_x[i]) begin
      r.out_x = pcr_pkg::coord_t'(cur_x[i][pcr_pkg::COORD_W-1:0]);
      r.out_y = pcr_pkg::coord_t'(cur_y[i][pcr_pkg::COORD_W-1:0]);
      r.has_vertex = 1'b1;
      r.polygon_done = 1'b0;
      res.push_back(r);
    end
    if (it.end_of_polygon) begin
      if (res.size() == 0) res.push_back('{0, 0, 1'b0, 1'b1});
      else res[res.size()-1].polygon_done = 1'b1;
    end
  endtask

  // Offers one item and waits until the block takes it. A random gap comes
  // first; the valid stays high across back-to-back items.
  task automatic send_vertex(pcr_pkg::in_item_t it, bit typed, pcr_pkg::out_item_t want);
    pcr_pkg::out_item_t res[$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    clip_vertex(it, res);
    if (typed) clipped_due.push_back(want);
    else foreach (res[i]) clipped_due.push_back(res[i]);
    items_sent++;
  endtask

  // Drops valid and waits until the block has drained, so the window can be
  // changed safely.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (clipped_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(longint mnx, longint mxx, longint mny, longint mxy);
    logic [pcr_pkg::CFG_IDX_W-1:0] idx [4];
    longint val [4];
    idx = '{pcr_pkg::CFG_MIN_X, pcr_pkg::CFG_MAX_X, pcr_pkg::CFG_MIN_Y, pcr_pkg::CFG_MAX_Y};
    val = '{mnx, mxx, mny, mxy};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i][pcr_pkg::COORD_W-1:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    win_min_x = longint'(pcr_pkg::coord_t'(mnx[pcr_pkg::COORD_W-1:0]));
    win_max_x = longint'(pcr_pkg::coord_t'(mxx[pcr_pkg::COORD_W-1:0]));
    win_min_y = longint'(pcr_pkg::coord_t'(mny[pcr_pkg::COORD_W-1:0]));
    win_max_y = longint'(pcr_pkg::coord_t'(mxy[pcr_pkg::COORD_W-1:0]));
  endtask

  // Mostly near the window so edges cross it; sometimes any 16-bit value.
  function automatic pcr_pkg::coord_t pick_coord(longint lo, longint hi);
    longint a, b, v;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    a = a - 100;
    b = b + 100;
    if (a < -32768) a = -32768;
    if (b > 32767) b = 32767;
    if ($urandom_range(7) == 0 || b - a > 60000) return pcr_pkg::coord_t'($urandom);
    v = a + longint'($urandom_range(int'(b - a)));
    return pcr_pkg::coord_t'(v[pcr_pkg::COORD_W-1:0]);
  endfunction

  // Sends random polygons of one to eight vertices until the item count
  // reaches the goal. A polygon is always closed before returning.
  task automatic random_polygons(int goal);
    pcr_pkg::in_item_t it;
    int n;
    while (items_sent < goal) begin
      n = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 2);
      for (int v = 0; v < n; v++) begin
        it.vertex_x = pick_coord(win_min_x, win_max_x);
        it.vertex_y = pick_coord(win_min_y, win_max_y);
        it.end_of_polygon = (v == n - 1);
        send_vertex(it, 1'b0, '0);
        // Idling pattern follows overall progress of the run.
        if (items_sent == 95) begin
          send_idle_pct = 46;
          recv_stall_pct = 6;
        end else if (items_sent == 190) begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      end
    end
  endtask

  // Receiver: random stall, and every accepted item is checked against the
  // oldest clipped vertex still due.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (clipped_due.size() == 0) begin
        $error("unexpected item x=%0d y=%0d", out_item.out_x, out_item.out_y);
        failed = 1'b1;
      end else begin
        if (out_item.out_x !== clipped_due[0].out_x) begin
          $error("out_x expected %0d actual %0d", clipped_due[0].out_x, out_item.out_x);
          failed = 1'b1;
        end
        if (out_item.out_y !== clipped_due[0].out_y) begin
          $error("out_y expected %0d actual %0d", clipped_due[0].out_y, out_item.out_y);
          failed = 1'b1;
        end
        if (out_item.has_vertex !== clipped_due[0].has_vertex) begin
          $error("has_vertex expected %0b actual %0b",
                 clipped_due[0].has_vertex, out_item.has_vertex);
          failed = 1'b1;
        end
        if (out_item.polygon_done !== clipped_due[0].polygon_done) begin
          $error("polygon_done expected %0b actual %0b",
                 clipped_due[0].polygon_done, out_item.polygon_done);
          failed = 1'b1;
        end
        void'(clipped_due.pop_front());
      end
    end
  end

  typedef struct {
    pcr_pkg::in_item_t  it;
    bit                 typed;
    pcr_pkg::out_item_t want;
  } vec_row_t;

  vec_row_t vec_rows[$];

  function automatic vec_row_t vec(int x, int y, bit last, bit typed = 0,
                                   pcr_pkg::out_item_t want = '0);
    vec_row_t r;
    r.it = '{pcr_pkg::coord_t'(x), pcr_pkg::coord_t'(y), last};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  initial begin
    // Directed vectors under the reset window (0..1023 by 0..767, strict).
    // A single inside vertex comes back as itself.
    vec_rows.push_back(vec(100, 100, 1, 1, '{16'sd100, 16'sd100, 1'b1, 1'b1}));
    // A single outside vertex, and single vertices on two corners, give the empty marker.
    vec_rows.push_back(vec(2000, 5, 1, 1, '{0, 0, 1'b0, 1'b1}));
    vec_rows.push_back(vec(0, 0, 1, 1, '{0, 0, 1'b0, 1'b1}));
    vec_rows.push_back(vec(1023, 767, 1, 1, '{0, 0, 1'b0, 1'b1}));
    // Triangle entering from the left and leaving through the bottom.
    vec_rows.push_back(vec(-100, 100, 0));
    vec_rows.push_back(vec(500, 100, 0));
    vec_rows.push_back(vec(500, 900, 1));
    // Coordinate extremes: the whole window survives as a rectangle.
    vec_rows.push_back(vec(-32768, -32768, 0));
    vec_rows.push_back(vec(32767, -32768, 0));
    vec_rows.push_back(vec(32767, 32767, 0));
    vec_rows.push_back(vec(-32768, 32767, 1));
    // Edge that starts on the left boundary and runs inside.
    vec_rows.push_back(vec(0, 100, 0));
    vec_rows.push_back(vec(200, 100, 0));
    vec_rows.push_back(vec(200, 300, 1));
    // Polygon entirely outside the window.
    vec_rows.push_back(vec(2000, 2000, 0));
    vec_rows.push_back(vec(3000, 2000, 0));
    vec_rows.push_back(vec(3000, 3000, 1));
    // Tie on rounding: crossing y falls on a half.
    vec_rows.push_back(vec(-1, 10, 0));
    vec_rows.push_back(vec(1, 11, 0));
    vec_rows.push_back(vec(1, 20, 1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 6;
    recv_stall_pct = 46;
    foreach (vec_rows[i]) send_vertex(vec_rows[i].it, vec_rows[i].typed, vec_rows[i].want);

    // Widest window: only the most negative and most positive values fall out.
    drain();
    write_window(-32768, 32767, -32768, 32767);
    random_polygons(80);

    // Inverted window: every vertex is rejected by some stage.
    drain();
    write_window(500, 100, 10, -10);
    random_polygons(120);

    // Random window of random size.
    drain();
    begin
      int base_x, base_y;
      base_x = $urandom_range(60000) - 32768;
      base_y = $urandom_range(60000) - 32768;
      write_window(base_x, base_x + $urandom_range(2000), base_y,
                   base_y + $urandom_range(2000));
    end
    random_polygons(200);

    // Tiny window, so nearly every edge crosses it.
    drain();
    write_window(-10, 10, -20, 5);
    random_polygons(260);

    in_valid <= 1'b0;
    @(posedge clk);
    while (clipped_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed && clipped_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
